// ===== sv/isws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package isws_pkg;

  // Default sizes
  localparam int unsigned DEPTH_DEF      = 256;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Command codes
  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_SEARCH = 3'd4
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_READ   = 2'd1,
    S_SEARCH = 2'd2
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;       // command beat taken this cycle
    logic read_done;    // top entry data is on the RAM output
    logic search_step;  // compare one entry this cycle
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_read;    // pop/peek on a non-empty stack
    logic need_search;  // search on a non-empty stack
    logic match;        // current entry equals the key
    logic last;         // current entry is the top one
  } ctl_stat_t;

endpackage

`default_nettype wire

// ===== sv/isws_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module isws_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/isws_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module isws_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  input  wire isws_pkg::ctl_stat_t stat_i,
  output isws_pkg::ctl_cmd_t       cmd_o,
  output logic                     busy
);

  isws_pkg::state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      isws_pkg::S_IDLE: begin
        if (start) begin
          if (stat_i.need_read) begin
            state_d = isws_pkg::S_READ;
          end else if (stat_i.need_search) begin
            state_d = isws_pkg::S_SEARCH;
          end
        end
      end
      isws_pkg::S_READ: begin
        state_d = isws_pkg::S_IDLE;
      end
      isws_pkg::S_SEARCH: begin
        if (stat_i.match || stat_i.last) begin
          state_d = isws_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = isws_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      isws_pkg::S_IDLE: begin
        busy         = 1'b0;
        cmd_o.accept = start;
      end
      isws_pkg::S_READ: begin
        cmd_o.read_done = 1'b1;
      end
      isws_pkg::S_SEARCH: begin
        cmd_o.search_step = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= isws_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/isws_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module isws_dpath #(
  parameter int unsigned DEPTH      = isws_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = isws_pkg::DATA_WIDTH_DEF,
  localparam int unsigned AW        = $clog2(DEPTH),
  localparam int unsigned CW        = $clog2(DEPTH + 1)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic        [CW-1:0]         cfg_data_i,
  input  wire logic        [2:0]            cmd_i,
  input  wire logic signed [DATA_WIDTH-1:0] operand_i,
  input  wire isws_pkg::ctl_cmd_t           ctl_i,
  output isws_pkg::ctl_stat_t               stat_o,
  output logic                              done_o,
  output logic             [1:0]            status_o,
  output logic signed      [DATA_WIDTH-1:0] read_value_o,
  output logic             [AW-1:0]         found_index_o,
  output logic             [CW-1:0]         count_o,
  output logic                              is_empty_o,
  output logic                              is_full_o
);

  logic [CW-1:0]         cap_q;
  logic [CW-1:0]         count_q, count_d;
  logic [DATA_WIDTH-1:0] key_q, key_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic                  done_q, done_d;
  isws_pkg::status_e     res_status_q, res_status_d;
  logic [DATA_WIDTH-1:0] res_value_q, res_value_d;
  logic [AW-1:0]         res_index_q, res_index_d;

  logic [CW-1:0]         ucap;
  logic                  empty;
  logic                  full;
  logic [CW-1:0]         count_m1;
  logic [AW-1:0]         idx_p1;
  logic                  ram_we;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic                  is_push, is_rd, is_search;
  logic                  hit, last;

  // Capacity saturates at the memory depth
  assign ucap     = (cap_q > CW'(DEPTH)) ? CW'(DEPTH) : cap_q;
  assign empty    = (count_q == '0);
  assign full     = (count_q >= ucap);
  assign count_m1 = count_q - CW'(1);
  assign idx_p1   = idx_q + AW'(1);

  // Command decode
  always_comb begin
    is_push   = 1'b0;
    is_rd     = 1'b0;
    is_search = 1'b0;
    unique case (cmd_i) inside
      isws_pkg::CMD_PUSH:                     is_push   = 1'b1;
      isws_pkg::CMD_POP, isws_pkg::CMD_PEEK:  is_rd     = 1'b1;
      isws_pkg::CMD_SEARCH:                   is_search = 1'b1;
      default: ;
    endcase
  end

  // Search compare on the registered RAM output
  assign hit  = (ram_rdata == key_q);
  assign last = ((CW'(idx_q) + CW'(1)) == count_q);

  assign stat_o.need_read   = is_rd && !empty;
  assign stat_o.need_search = is_search && !empty;
  assign stat_o.match       = hit;
  assign stat_o.last        = last;

  // Memory ports
  assign ram_we    = ctl_i.accept && is_push && !full;
  assign ram_raddr = ctl_i.search_step ? idx_p1 :
                     (is_search ? '0 : count_m1[AW-1:0]);

  isws_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (operand_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Command execution and result capture
  always_comb begin
    count_d      = count_q;
    key_d        = key_q;
    idx_d        = idx_q;
    done_d       = 1'b0;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    res_index_d  = res_index_q;

    if (ctl_i.accept) begin
      key_d        = operand_i;
      idx_d        = '0;
      res_status_d = isws_pkg::ST_OK;
      res_value_d  = '0;
      res_index_d  = '0;
      done_d       = 1'b1;
      case (cmd_i)
        isws_pkg::CMD_PUSH: begin
          if (full) begin
            res_status_d = isws_pkg::ST_OVERFLOW;
          end else begin
            count_d = count_q + CW'(1);
          end
        end
        isws_pkg::CMD_POP: begin
          if (empty) begin
            res_status_d = isws_pkg::ST_EMPTY;
          end else begin
            count_d = count_m1;
            done_d  = 1'b0;
          end
        end
        isws_pkg::CMD_PEEK: begin
          if (empty) begin
            res_status_d = isws_pkg::ST_EMPTY;
          end else begin
            done_d = 1'b0;
          end
        end
        isws_pkg::CMD_CLEAR: begin
          count_d = '0;
        end
        isws_pkg::CMD_SEARCH: begin
          if (empty) begin
            res_status_d = isws_pkg::ST_NOT_FOUND;
          end else begin
            done_d = 1'b0;
          end
        end
        default: ;
      endcase
    end else if (ctl_i.read_done) begin
      res_value_d = ram_rdata;
      done_d      = 1'b1;
    end else if (ctl_i.search_step) begin
      if (hit) begin
        res_index_d = idx_q;
        done_d      = 1'b1;
      end else if (last) begin
        res_status_d = isws_pkg::ST_NOT_FOUND;
        done_d       = 1'b1;
      end else begin
        idx_d = idx_p1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CW'(DEPTH);
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    res_index_q  <= res_index_d;
  end

  assign done_o        = done_q;
  assign status_o      = res_status_q;
  assign read_value_o  = res_value_q;
  assign found_index_o = res_index_q;
  assign count_o       = count_q;
  assign is_empty_o    = empty;
  assign is_full_o     = full;

endmodule

`default_nettype wire

// ===== sv/int_stack_with_search.sv =====
// Push, clear, unused codes, and any command on an empty stack: result in the cycle after start is taken.
// Pop and peek on a non-empty stack: the top entry passes the registered RAM read, then the result register.
// Search: entries are compared from index 0 up to count, one RAM read per cycle, until a match or the top one.
// Throughput: one command per result; busy is high while a read or search runs.
// The receiver cannot stall: done_o marks each result for exactly one cycle.
// Reset: count cleared, capacity set to DEPTH; the entry memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module int_stack_with_search #(
  parameter int unsigned DEPTH      = isws_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = isws_pkg::DATA_WIDTH_DEF,
  localparam int unsigned AW        = $clog2(DEPTH),
  localparam int unsigned CW        = $clog2(DEPTH + 1)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration channel
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic        [CW-1:0]         cfg_data_i,
  // command
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic        [2:0]            cmd_i,
  input  wire logic signed [DATA_WIDTH-1:0] operand_i,
  // result
  output logic                              done_o,
  output logic             [1:0]            status_o,
  output logic signed      [DATA_WIDTH-1:0] read_value_o,
  output logic             [AW-1:0]         found_index_o,
  output logic             [CW-1:0]         count_o,
  output logic                              is_empty_o,
  output logic                              is_full_o
);

  isws_pkg::ctl_cmd_t  ctl_cmd;
  isws_pkg::ctl_stat_t ctl_stat;
  logic                cfg_we;

  // Capacity register takes a beat at any time
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  isws_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (ctl_stat),
    .cmd_o  (ctl_cmd),
    .busy   (busy)
  );

  isws_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd_i),
    .operand_i     (operand_i),
    .ctl_i         (ctl_cmd),
    .stat_o        (ctl_stat),
    .done_o        (done_o),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .found_index_o (found_index_o),
    .count_o       (count_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o)
  );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned STACK_DEPTH  = isws_pkg::DEPTH_DEF;
  localparam int unsigned QUIET_LIMIT  = 2000;  // cycles with no beat at all
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned PHASE_ITEMS  = 55;
  localparam logic [2:0]  CMD_SPARE_LO  = 3'd5;  // unused command codes
  localparam logic [2:0]  CMD_SPARE_MID = 3'd6;
  localparam logic [2:0]  CMD_SPARE_HI  = 3'd7;

  // One result beat
  typedef struct {
    isws_pkg::status_e status;
    logic [31:0]       rd;
    logic [7:0]        idx;
    logic [8:0]        cnt;
    logic              empty;
    logic              full;
  } stack_result_t;

  // One row of the directed table: a capacity write or a command
  typedef struct {
    bit            cap_write;
    logic [8:0]    cap;
    logic [2:0]    op;
    logic [31:0]   arg;
    bit            typed;
    stack_result_t want;
  } step_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic        [8:0]  cfg_data_i;
  logic               start;
  logic               busy;
  logic        [2:0]  cmd_i;
  logic signed [31:0] operand_i;
  logic               done_o;
  logic        [1:0]  status_o;
  logic signed [31:0] read_value_o;
  logic        [7:0]  found_index_o;
  logic        [8:0]  count_o;
  logic               is_empty_o;
  logic               is_full_o;

  // Directed rows carry their own expected result alongside the command
  bit            row_typed;
  stack_result_t row_want;
  stack_result_t no_want;

  // Shadow of the stack and its capacity register
  logic [31:0]   stack_mem [STACK_DEPTH];
  int unsigned   fill = 0;
  logic [8:0]    cap_reg = 9'd256;

  stack_result_t results_due [$];
  step_row_t     steps [$];
  int unsigned   errors = 0;
  int unsigned   quiet = 0;
  bit            steady = 0;
  int unsigned   phase_caps [9] = '{256, 3, 0, 511, 1, 8, 257, 0, 256};

  int_stack_with_search dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .operand_i    (operand_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .found_index_o(found_index_o),
    .count_o      (count_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Apply one command to the shadow stack and return the result it owes
  function automatic stack_result_t stack_apply(input logic [2:0] op, input logic [31:0] arg);
    stack_result_t r;
    int unsigned   lim;
    int unsigned   i;
    bit            hit;
    lim = (cap_reg > STACK_DEPTH) ? STACK_DEPTH : cap_reg;
    r.status = isws_pkg::ST_OK;
    r.rd = '0;
    r.idx = '0;
    hit = 1'b0;
    case (op)
      isws_pkg::CMD_PUSH: begin
        if (fill >= lim) begin
          r.status = isws_pkg::ST_OVERFLOW;
        end else begin
          stack_mem[fill] = arg;
          fill++;
        end
      end
      isws_pkg::CMD_POP: begin
        if (fill == 0) begin
          r.status = isws_pkg::ST_EMPTY;
        end else begin
          fill--;
          r.rd = stack_mem[fill];
        end
      end
      isws_pkg::CMD_PEEK: begin
        if (fill == 0) r.status = isws_pkg::ST_EMPTY;
        else r.rd = stack_mem[fill-1];
      end
      isws_pkg::CMD_CLEAR: fill = 0;
      isws_pkg::CMD_SEARCH: begin
        // lowest matching index wins
        r.status = isws_pkg::ST_NOT_FOUND;
        for (i = 0; i < fill && !hit; i++) begin
          if (stack_mem[i] == arg) begin
            hit = 1'b1;
            r.status = isws_pkg::ST_OK;
            r.idx = i[7:0];
          end
        end
      end
      default: ;
    endcase
    r.cnt = fill[8:0];
    r.empty = (fill == 0);
    r.full = (fill >= lim);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= REPORT_MAX)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  // Monitor: result beats are checked, command beats predicted (typed rows use their own result), cfg beats tracked
  always @(posedge clk_i) begin
    stack_result_t want;
    stack_result_t predicted;
    bit            moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (done_o) begin
        moved = 1'b1;
        if (results_due.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("unexpected result beat: status %0d count %0d", status_o, count_o);
        end else begin
          want = results_due.pop_front();
          check_field("status", want.status, status_o);
          check_field("read_value", want.rd, read_value_o);
          check_field("found_index", want.idx, found_index_o);
          check_field("count", want.cnt, count_o);
          check_field("is_empty", want.empty, is_empty_o);
          check_field("is_full", want.full, is_full_o);
        end
      end
      if (start && !busy) begin
        moved = 1'b1;
        predicted = stack_apply(cmd_i, operand_i);
        if (row_typed) predicted = row_want;
        results_due.push_back(predicted);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        cap_reg = cfg_data_i;
      end
      // watchdog
      if (moved) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  function automatic void cmd_row(input logic [2:0] op, input logic [31:0] arg, input bit typed,
                                  input isws_pkg::status_e st, input logic [31:0] rd,
                                  input logic [7:0] idx, input logic [8:0] cnt, input bit full);
    step_row_t s;
    s.cap_write = 1'b0;
    s.cap = '0;
    s.op = op;
    s.arg = arg;
    s.typed = typed;
    s.want.status = st;
    s.want.rd = rd;
    s.want.idx = idx;
    s.want.cnt = cnt;
    s.want.empty = (cnt == 0);
    s.want.full = full;
    steps.push_back(s);
  endfunction

  function automatic void cap_row(input logic [8:0] cap);
    step_row_t s;
    s.cap_write = 1'b1;
    s.cap = cap;
    s.op = '0;
    s.arg = '0;
    s.typed = 1'b0;
    s.want = no_want;
    steps.push_back(s);
  endfunction

  // Present one command beat; returns at the falling edge after it is taken,
  // with start still high so a following beat can go out back to back
  task automatic issue(input logic [2:0] op, input logic [31:0] arg, input bit typed,
                       input stack_result_t want);
    start = 1'b1;
    cmd_i = op;
    operand_i = arg;
    row_typed = typed;
    row_want = want;
    // busy only moves at the rising edge, so it is stable here
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Random gap between command beats: mostly none or short, a few long
  task automatic pause();
    int unsigned roll;
    int unsigned n;
    if (steady) return;
    roll = $urandom_range(0, 99);
    n = (roll < 55) ? 0 : (roll < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (n == 0) return;
    start = 1'b0;
    row_typed = 1'b0;
    cmd_i = 3'($urandom);
    operand_i = $urandom;
    repeat (n) @(negedge clk_i);
  endtask

  // Capacity writes only once the block is idle and every result is in
  task automatic set_capacity(input logic [8:0] cap);
    start = 1'b0;
    row_typed = 1'b0;
    while (results_due.size() != 0) @(negedge clk_i);
    repeat ($urandom_range(2, 6)) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = cap;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_data_i = 9'($urandom);
  endtask

  // Small values collide often, so searches hit and duplicates appear
  function automatic logic [31:0] pick_word();
    int unsigned roll;
    logic [31:0] w;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      w = $urandom_range(0, 15);
    end else if (roll < 50) begin
      case ($urandom_range(0, 3))
        0: w = 32'h0000_0000;
        1: w = 32'hFFFF_FFFF;
        2: w = 32'h7FFF_FFFF;
        default: w = 32'h8000_0000;
      endcase
    end else begin
      w = $urandom;
    end
    return w;
  endfunction

  function automatic logic [31:0] pick_key();
    if (fill != 0 && $urandom_range(0, 99) < 65)
      return stack_mem[$urandom_range(0, fill - 1)];
    return pick_word();
  endfunction

  task automatic random_item();
    int unsigned roll;
    logic [2:0]  op;
    logic [31:0] arg;
    roll = $urandom_range(0, 99);
    if (roll < 40) op = isws_pkg::CMD_PUSH;
    else if (roll < 65) op = isws_pkg::CMD_POP;
    else if (roll < 73) op = isws_pkg::CMD_PEEK;
    else if (roll < 93) op = isws_pkg::CMD_SEARCH;
    else if (roll < 96) op = isws_pkg::CMD_CLEAR;
    else op = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    arg = (op == isws_pkg::CMD_SEARCH) ? pick_key() : pick_word();
    issue(op, arg, 1'b0, no_want);
    pause();
  endtask

  task automatic run_phase(input int unsigned p);
    logic [8:0] cap;
    cap = (p == 7) ? 9'($urandom_range(0, 511)) : 9'(phase_caps[p]);
    set_capacity(cap);
    steady = (p % 3 == 1);
    repeat (PHASE_ITEMS) random_item();
    steady = 1'b0;
  endtask

  // Stimulus
  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = isws_pkg::CMD_PUSH;
    operand_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    row_typed = 1'b0;
    no_want.status = isws_pkg::ST_OK;
    no_want.rd = '0;
    no_want.idx = '0;
    no_want.cnt = '0;
    no_want.empty = 1'b0;
    no_want.full = 1'b0;
    row_want = no_want;

    // Directed table: empty stack after reset, word extremes, search order,
    // capacity at and below the count, capacity zero and above the depth
    cmd_row(isws_pkg::CMD_POP,    32'h0000_0000, 1, isws_pkg::ST_EMPTY,     '0, 0, 0, 0);
    cmd_row(isws_pkg::CMD_PEEK,   32'h0000_0000, 1, isws_pkg::ST_EMPTY,     '0, 0, 0, 0);
    cmd_row(isws_pkg::CMD_SEARCH, 32'h0000_0000, 1, isws_pkg::ST_NOT_FOUND, '0, 0, 0, 0);
    cmd_row(CMD_SPARE_LO,         32'hFFFF_FFFF, 1, isws_pkg::ST_OK,        '0, 0, 0, 0);
    cmd_row(CMD_SPARE_HI,         32'h0000_0000, 1, isws_pkg::ST_OK,        '0, 0, 0, 0);
    cmd_row(isws_pkg::CMD_PUSH,   32'h7FFF_FFFF, 1, isws_pkg::ST_OK,        '0, 0, 1, 0);
    cmd_row(isws_pkg::CMD_PUSH,   32'h8000_0000, 1, isws_pkg::ST_OK,        '0, 0, 2, 0);
    cmd_row(isws_pkg::CMD_PUSH,   32'hFFFF_FFFF, 1, isws_pkg::ST_OK,        '0, 0, 3, 0);
    cmd_row(isws_pkg::CMD_PUSH,   32'h7FFF_FFFF, 1, isws_pkg::ST_OK,        '0, 0, 4, 0);
    cmd_row(isws_pkg::CMD_SEARCH, 32'h7FFF_FFFF, 1, isws_pkg::ST_OK,        '0, 0, 4, 0);
    cmd_row(isws_pkg::CMD_SEARCH, 32'hFFFF_FFFF, 1, isws_pkg::ST_OK,        '0, 2, 4, 0);
    cmd_row(isws_pkg::CMD_SEARCH, 32'h0000_0001, 1, isws_pkg::ST_NOT_FOUND, '0, 0, 4, 0);
    cmd_row(isws_pkg::CMD_PEEK, 32'h0000_0000, 1, isws_pkg::ST_OK, 32'h7FFF_FFFF, 0, 4, 0);
    cmd_row(isws_pkg::CMD_POP,  32'h0000_0000, 1, isws_pkg::ST_OK, 32'h7FFF_FFFF, 0, 3, 0);
    cmd_row(isws_pkg::CMD_POP,  32'h0000_0000, 1, isws_pkg::ST_OK, 32'hFFFF_FFFF, 0, 2, 0);
    cap_row(9'd2);
    cmd_row(isws_pkg::CMD_PUSH,   32'h0000_0005, 1, isws_pkg::ST_OVERFLOW,  '0, 0, 2, 1);
    cap_row(9'd1);
    cmd_row(isws_pkg::CMD_POP,  32'h0000_0000, 1, isws_pkg::ST_OK, 32'h8000_0000, 0, 1, 1);
    cmd_row(isws_pkg::CMD_POP,  32'h0000_0000, 1, isws_pkg::ST_OK, 32'h7FFF_FFFF, 0, 0, 0);
    cap_row(9'd0);
    cmd_row(isws_pkg::CMD_PUSH,   32'h0000_0001, 1, isws_pkg::ST_OVERFLOW,  '0, 0, 0, 1);
    cmd_row(isws_pkg::CMD_SEARCH, 32'h0000_0001, 1, isws_pkg::ST_NOT_FOUND, '0, 0, 0, 1);
    cap_row(9'd511);
    cmd_row(isws_pkg::CMD_PUSH,   32'h0000_0000, 1, isws_pkg::ST_OK,        '0, 0, 1, 0);
    cmd_row(isws_pkg::CMD_PUSH,   32'h1234_5678, 0, isws_pkg::ST_OK,        '0, 0, 0, 0);
    cmd_row(isws_pkg::CMD_SEARCH, 32'h1234_5678, 0, isws_pkg::ST_OK,        '0, 0, 0, 0);
    cmd_row(isws_pkg::CMD_CLEAR,  32'h0000_0000, 1, isws_pkg::ST_OK,        '0, 0, 0, 0);
    cmd_row(CMD_SPARE_MID,        32'h0000_0000, 1, isws_pkg::ST_OK,        '0, 0, 0, 0);
    cap_row(9'd256);

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (steps[k]) begin
      if (steps[k].cap_write) begin
        set_capacity(steps[k].cap);
      end else begin
        issue(steps[k].op, steps[k].arg, steps[k].typed, steps[k].want);
        pause();
      end
    end

    // Random phases; the count carries over, so later capacities can land below it
    for (int p = 0; p < 4; p++) run_phase(p);

    // Fill to the full depth with capacity above it, then overflow and deep searches
    set_capacity(9'd300);
    while (fill < STACK_DEPTH) begin
      issue(isws_pkg::CMD_PUSH, $urandom, 1'b0, no_want);
      pause();
    end
    repeat (2) begin
      issue(isws_pkg::CMD_PUSH, pick_word(), 1'b0, no_want);
      pause();
    end
    issue(isws_pkg::CMD_PEEK, '0, 1'b0, no_want);
    issue(isws_pkg::CMD_SEARCH, stack_mem[STACK_DEPTH-1], 1'b0, no_want);
    pause();
    issue(isws_pkg::CMD_SEARCH, stack_mem[0], 1'b0, no_want);
    issue(isws_pkg::CMD_SEARCH, stack_mem[STACK_DEPTH/2], 1'b0, no_want);
    pause();
    issue(isws_pkg::CMD_SEARCH, $urandom, 1'b0, no_want);
    repeat (3) begin
      issue(isws_pkg::CMD_POP, pick_word(), 1'b0, no_want);
      pause();
    end
    issue(isws_pkg::CMD_SEARCH, stack_mem[fill-1], 1'b0, no_want);
    issue(isws_pkg::CMD_CLEAR, pick_word(), 1'b0, no_want);

    for (int p = 4; p < 9; p++) run_phase(p);

    // Drain, then let the block settle
    start = 1'b0;
    row_typed = 1'b0;
    while (results_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    errors += results_due.size();

    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
